@@ hw/rtl/qvr_pkg.sv @@
`timescale 1ns / 1ps

package qvr_pkg;

    // Component width of every input and result field.
    localparam int DATA_W = 16;
    localparam int IN_W   = 7 * DATA_W;
    localparam int OUT_W  = ((3 * DATA_W + 7) / 8) * 8;

    // Intermediate widths, worst case over all 16-bit inputs.
    localparam int PROD_W = 2 * DATA_W;          // u_a * v_b, squares
    localparam int A_W    = 2 * DATA_W + 2;      // w^2 + ui^2 - uj^2 - uk^2
    localparam int BC_W   = 2 * DATA_W + 1;      // sum or difference of two products
    localparam int NRM_W  = 2 * DATA_W + 1;      // squared norm, unsigned
    localparam int SUM_W  = 3 * DATA_W + 2;      // signed numerator
    localparam int NUM_W  = 3 * DATA_W + 3;      // 2|s| + n
    localparam int DEN_W  = 2 * DATA_W + 2;      // 2n
    localparam int QUO_W  = DATA_W;              // quotient bits kept

    localparam logic [QUO_W-1:0] HALF = QUO_W'(1) << (DATA_W - 1);

    typedef struct packed {
        logic [2:0][SUM_W-1:0] sum;
        logic [NRM_W-1:0]      nrm;
        logic                  zero;
    } t_front;

    typedef struct packed {
        logic [2:0][QUO_W-1:0] quo;
        logic [2:0]            neg;
        logic [2:0]            ovf;
        logic                  zero;
    } t_quot;

endpackage

@@ hw/rtl/qvr_arith.sv @@
`timescale 1ns / 1ps

module qvr_arith (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [qvr_pkg::IN_W-1:0] i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output qvr_pkg::t_front        o_front
);
    import qvr_pkg::*;

    logic [4:1] r_vld;
    logic [5:1] rdy;

    // stage 1: squares of u and w, and all u*v products
    logic signed [PROD_W-1:0] r_sq [4];
    logic signed [PROD_W-1:0] r_uv [3][3];
    logic signed [DATA_W-1:0] r1_u [3];
    logic signed [DATA_W-1:0] r1_v [3];
    logic signed [DATA_W-1:0] r1_w;
    // stage 2: per-component factors
    logic signed [A_W-1:0]    r_a [3];
    logic signed [BC_W-1:0]   r_b [3];
    logic signed [BC_W-1:0]   r_c [3];
    logic [NRM_W-1:0]         r2_n;
    logic signed [DATA_W-1:0] r2_u [3];
    logic signed [DATA_W-1:0] r2_v [3];
    logic signed [DATA_W-1:0] r2_w;
    // stage 3: second multiplications
    logic signed [SUM_W-1:0]  r_p1 [3];
    logic signed [SUM_W-1:0]  r_p2 [3];
    logic signed [SUM_W-1:0]  r_p3 [3];
    logic [NRM_W-1:0]         r3_n;
    // stage 4: numerator
    logic signed [SUM_W-1:0]  r_s [3];
    logic [NRM_W-1:0]         r4_n;

    logic signed [DATA_W-1:0] u_in [3];
    logic signed [DATA_W-1:0] v_in [3];
    logic signed [DATA_W-1:0] w_in;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u_in[i] = $signed(i_data[i*DATA_W +: DATA_W]);
            v_in[i] = $signed(i_data[(4+i)*DATA_W +: DATA_W]);
        end
        w_in = $signed(i_data[3*DATA_W +: DATA_W]);
    end

    always_comb begin
        rdy[5] = i_ready;
        for (int k = 4; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end
    assign o_ready = rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) r_vld[1] <= i_valid;
            if (rdy[2]) r_vld[2] <= r_vld[1];
            if (rdy[3]) r_vld[3] <= r_vld[2];
            if (rdy[4]) r_vld[4] <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= PROD_W'(u_in[i]) * PROD_W'(u_in[i]);
                for (int b = 0; b < 3; b++) begin
                    r_uv[i][b] <= PROD_W'(u_in[i]) * PROD_W'(v_in[b]);
                end
            end
            r_sq[3] <= PROD_W'(w_in) * PROD_W'(w_in);
            r1_u    <= u_in;
            r1_v    <= v_in;
            r1_w    <= w_in;
        end
        if (rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= A_W'(r_sq[3]) + A_W'(r_sq[i])
                        - A_W'(r_sq[(i+1)%3]) - A_W'(r_sq[(i+2)%3]);
                r_b[i] <= BC_W'(r_uv[(i+1)%3][(i+1)%3]) + BC_W'(r_uv[(i+2)%3][(i+2)%3]);
                r_c[i] <= BC_W'(r_uv[(i+1)%3][(i+2)%3]) - BC_W'(r_uv[(i+2)%3][(i+1)%3]);
            end
            r2_n <= NRM_W'($unsigned(r_sq[0])) + NRM_W'($unsigned(r_sq[1]))
                  + NRM_W'($unsigned(r_sq[2])) + NRM_W'($unsigned(r_sq[3]));
            r2_u <= r1_u;
            r2_v <= r1_v;
            r2_w <= r1_w;
        end
        if (rdy[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_p1[i] <= SUM_W'(r2_v[i]) * SUM_W'(r_a[i]);
                r_p2[i] <= SUM_W'(r2_u[i]) * SUM_W'(r_b[i]);
                r_p3[i] <= SUM_W'(r2_w) * SUM_W'(r_c[i]);
            end
            r3_n <= r2_n;
        end
        if (rdy[4]) begin
            for (int i = 0; i < 3; i++) begin
                r_s[i] <= r_p1[i] + (r_p2[i] <<< 1) + (r_p3[i] <<< 1);
            end
            r4_n <= r3_n;
        end
    end

    assign o_valid = r_vld[4];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_front.sum[i] = r_s[i];
        end
        o_front.nrm  = r4_n;
        o_front.zero = (r4_n == '0);
    end

endmodule

@@ hw/rtl/qvr_div.sv @@
`timescale 1ns / 1ps

module qvr_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qvr_pkg::t_front i_front,
    output logic            o_valid,
    input  logic            i_ready,
    output qvr_pkg::t_quot  o_quot
);
    import qvr_pkg::*;

    // Stage 0 forms 2|s| + n and 2n; stages 1..QUO_W each settle one
    // quotient bit, most significant first.
    logic [QUO_W:0]    r_vld;
    logic [QUO_W+1:0]  rdy;
    logic [NUM_W-1:0]  r_rem [QUO_W+1][3];
    logic [QUO_W-1:0]  r_q   [QUO_W+1][3];
    logic [DEN_W-1:0]  r_den [QUO_W+1];
    logic [2:0]        r_neg [QUO_W+1];
    logic [2:0]        r_ovf [QUO_W+1];
    logic              r_zero[QUO_W+1];

    logic [NUM_W-1:0]  num0 [3];
    logic [DEN_W-1:0]  den0;
    logic [2:0]        neg0;
    logic [2:0]        ovf0;

    always_comb begin
        den0 = DEN_W'(i_front.nrm) << 1;
        for (int i = 0; i < 3; i++) begin
            neg0[i] = i_front.sum[i][SUM_W-1];
            num0[i] = (neg0[i] ? NUM_W'(-$signed(i_front.sum[i])) : NUM_W'(i_front.sum[i]))
                      << 1;
            num0[i] = num0[i] + NUM_W'(i_front.nrm);
            ovf0[i] = num0[i] >= (NUM_W'(den0) << QUO_W);
        end
    end

    always_comb begin
        rdy[QUO_W+1] = i_ready;
        for (int k = QUO_W; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end
    assign o_ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k <= QUO_W; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= num0[i];
                r_q[0][i]   <= '0;
            end
            r_den[0]  <= den0;
            r_neg[0]  <= neg0;
            r_ovf[0]  <= ovf0;
            r_zero[0] <= i_front.zero;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [NUM_W-1:0] dsh;
        assign dsh = NUM_W'(r_den[k-1]) << (QUO_W - k);
        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[k-1][i] >= dsh) begin
                        r_rem[k][i] <= r_rem[k-1][i] - dsh;
                        r_q[k][i]   <= r_q[k-1][i] | (QUO_W'(1) << (QUO_W - k));
                    end else begin
                        r_rem[k][i] <= r_rem[k-1][i];
                        r_q[k][i]   <= r_q[k-1][i];
                    end
                end
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    assign o_valid = r_vld[QUO_W];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_quot.quo[i] = r_q[QUO_W][i];
        end
        o_quot.neg  = r_neg[QUO_W];
        o_quot.ovf  = r_ovf[QUO_W];
        o_quot.zero = r_zero[QUO_W];
    end

endmodule

@@ hw/rtl/quaternion_vector_rotate.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// slave     in         i_s_tvalid / o_s_tready     quaternion x,y,z,w and vector x,y,z
// master    out        o_m_tvalid / i_m_tready     rotated x,y,z; flags in tuser
//
// One word enters per clock when the output side keeps up. A word passes 22
// register stages: four arithmetic stages, one setup stage and sixteen
// quotient stages of the divider (one quotient bit each), and the output
// register, which drives the master channel. Every stage holds its own
// valid bit, so a stall only backs up until an empty stage is found.
// Reset clears the valid bits only.

module quaternion_vector_rotate (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z (16 bits each)
    input  logic [qvr_pkg::IN_W-1:0]   i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // rot_x, rot_y, rot_z (16 bits each)
    output logic [qvr_pkg::OUT_W-1:0]  o_m_tdata,
    // zero_quat, saturated
    output logic [1:0]                 o_m_tuser
);
    import qvr_pkg::*;

    logic   front_vld, front_rdy;
    t_front front;
    logic   quot_vld, quot_rdy;
    t_quot  quot;

    logic                         r_out_vld;
    logic [2:0][DATA_W-1:0]       r_rot;
    logic                         r_zero;
    logic                         r_sat;

    logic [2:0][DATA_W-1:0]       n_rot;
    logic                         n_sat;
    logic [QUO_W-1:0]             mag;
    logic                         clip;

    qvr_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_valid (front_vld),
        .i_ready (front_rdy),
        .o_front (front)
    );

    qvr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_vld),
        .o_ready (front_rdy),
        .i_front (front),
        .o_valid (quot_vld),
        .i_ready (quot_rdy),
        .o_quot  (quot)
    );

    assign quot_rdy = !r_out_vld || i_m_tready;

    // Clip the rounded magnitude to the signed range, then apply the sign.
    // A zero quaternion forces zero results and no saturation.
    always_comb begin
        n_sat = 1'b0;
        mag   = '0;
        clip  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (quot.neg[i]) begin
                clip = quot.ovf[i] || (quot.quo[i] > HALF);
                mag  = clip ? HALF : quot.quo[i];
            end else begin
                clip = quot.ovf[i] || (quot.quo[i] > HALF - 1'b1);
                mag  = clip ? HALF - 1'b1 : quot.quo[i];
            end
            n_rot[i] = quot.neg[i] ? DATA_W'(~mag + 1'b1) : DATA_W'(mag);
            n_sat    = n_sat | clip;
            if (quot.zero) begin
                n_rot[i] = '0;
            end
        end
        if (quot.zero) begin
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (quot_rdy) begin
            r_out_vld <= quot_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (quot_rdy) begin
            r_rot  <= n_rot;
            r_zero <= quot.zero;
            r_sat  <= n_sat;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_W'(r_rot);
    assign o_m_tuser  = {r_sat, r_zero};

endmodule

@@ verif/tb_quaternion_vector_rotate.sv @@
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate;
    import qvr_pkg::*;

    // One input word, fields in tdata order from the lowest bit up.
    typedef struct {
        logic signed [15:0] qx, qy, qz, qw, vx, vy, vz;
    } rot_in_t;

    // One result word: rotated vector and the two flags.
    typedef struct {
        logic [15:0] rx, ry, rz;
        logic        zero_q;
        logic        sat;
    } rot_out_t;

    // Scoreboard: predicts each rotation when its word is accepted and
    // compares the outputs in order.
    class rotation_scoreboard;
        rot_out_t pending[$];
        int       errors;
        int       checked;
        int       sat_seen;
        int       zero_seen;

        // Rounds N/n to nearest (ties away from zero) and clips to 16 bits.
        function automatic logic [15:0] round_clip(longint num, longint nrm, ref logic sat);
            longint mag;
            longint quo;
            mag = (num < 0) ? -num : num;
            quo = (2 * mag + nrm) / (2 * nrm);
            if (num < 0) begin
                if (quo > 32768) begin
                    quo = 32768;
                    sat = 1'b1;
                end
                return 16'(-quo);
            end else begin
                if (quo > 32767) begin
                    quo = 32767;
                    sat = 1'b1;
                end
                return 16'(quo);
            end
        endfunction

        function automatic void note_input(rot_in_t w);
            longint u[3];
            longint v[3];
            longint qw;
            longint nrm;
            longint num;
            logic [15:0] res[3];
            rot_out_t e;
            int j;
            int k;
            u[0] = w.qx; u[1] = w.qy; u[2] = w.qz; qw = w.qw;
            v[0] = w.vx; v[1] = w.vy; v[2] = w.vz;
            nrm = u[0]*u[0] + u[1]*u[1] + u[2]*u[2] + qw*qw;
            e.sat = 1'b0;
            if (nrm == 0) begin
                e.rx = '0; e.ry = '0; e.rz = '0;
                e.zero_q = 1'b1;
            end else begin
                e.zero_q = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    num = v[i] * (qw*qw + u[i]*u[i] - u[j]*u[j] - u[k]*u[k])
                        + 2 * u[i] * (u[j]*v[j] + u[k]*v[k])
                        + 2 * qw * (u[j]*v[k] - u[k]*v[j]);
                    res[i] = round_clip(num, nrm, e.sat);
                end
                e.rx = res[0]; e.ry = res[1]; e.rz = res[2];
            end
            pending.push_back(e);
        endfunction

        function automatic void check_result(logic [OUT_W-1:0] data, logic [1:0] user);
            rot_out_t e;
            rot_out_t a;
            a.rx = data[15:0]; a.ry = data[31:16]; a.rz = data[47:32];
            a.zero_q = user[0]; a.sat = user[1];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h user=%b",
                         $time, a.rx, a.ry, a.rz, user);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (a.zero_q) zero_seen++;
            if (a.sat) sat_seen++;
            if (a.rx !== e.rx)
                $display("%0t: rot_x expected %h actual %h", $time, e.rx, a.rx);
            if (a.ry !== e.ry)
                $display("%0t: rot_y expected %h actual %h", $time, e.ry, a.ry);
            if (a.rz !== e.rz)
                $display("%0t: rot_z expected %h actual %h", $time, e.rz, a.rz);
            if (a.zero_q !== e.zero_q)
                $display("%0t: zero_quat expected %b actual %b", $time, e.zero_q, a.zero_q);
            if (a.sat !== e.sat)
                $display("%0t: saturated expected %b actual %b", $time, e.sat, a.sat);
            if (a.rx !== e.rx || a.ry !== e.ry || a.rz !== e.rz ||
                a.zero_q !== e.zero_q || a.sat !== e.sat)
                errors++;
        endfunction
    endclass

    localparam int STALL_LIMIT = 3000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [OUT_W-1:0]  o_m_tdata;
    logic [1:0]        o_m_tuser;

    rotation_scoreboard rot_sb;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int words_sent;

    quaternion_vector_rotate dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver backpressure follows the current stall rate.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Output monitor and the watchdog on accepted words.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                rot_sb.check_result(o_m_tdata, o_m_tuser);
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time,
                         rot_sb.pending.size());
                $display("FAIL quaternion_vector_rotate");
                $finish;
            end
        end
    end

    // Presents one word, with random idle cycles first; valid stays high
    // across back-to-back words.
    task automatic send_word(rot_in_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {w.vz, w.vy, w.vx, w.qw, w.qz, w.qy, w.qx};
        do @(posedge i_clk); while (!o_s_tready);
        rot_sb.note_input(w);
        words_sent++;
    endtask

    task automatic send_fields(int qx, int qy, int qz, int qw, int vx, int vy, int vz);
        rot_in_t w;
        w.qx = qx; w.qy = qy; w.qz = qz; w.qw = qw;
        w.vx = vx; w.vy = vy; w.vz = vz;
        send_word(w);
    endtask

    function automatic logic [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(8192)) - 4096);
            2: return 16'($signed($urandom_range(6)) - 3);
            default: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
        endcase
    endfunction

    // Random words: mostly full-range values, plus small quaternions (coarse
    // rounding and ties), zero quaternions and extreme components.
    task automatic send_random(int count);
        rot_in_t w;
        int qmode;
        for (int i = 0; i < count; i++) begin
            qmode = $urandom_range(9);
            qmode = (qmode < 5) ? 0 : (qmode < 7) ? 1 : (qmode < 9) ? 2 : 3;
            w.qx = rand_comp(qmode); w.qy = rand_comp(qmode);
            w.qz = rand_comp(qmode); w.qw = rand_comp(qmode);
            if ($urandom_range(19) == 0) begin
                w.qx = '0; w.qy = '0; w.qz = '0; w.qw = '0;
            end
            w.vx = rand_comp($urandom_range(3) == 0 ? 3 : 0);
            w.vy = rand_comp(0);
            w.vz = rand_comp($urandom_range(1));
            send_word(w);
        end
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (rot_sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        rot_sb = new();
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        quiet_cycles = 0;
        words_sent = 0;
        send_idle_pct = 12;
        recv_stall_pct = 73;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: zero quaternion, identity, non-unit scale, extremes,
        // tiny quaternions where rounding ties occur, and saturating rotations.
        send_fields(0, 0, 0, 0, 4096, -4096, 123);
        send_fields(0, 0, 0, 0, -32768, 32767, -32768);
        send_fields(0, 0, 0, 4096, 4096, 8192, -12288);
        send_fields(0, 0, 0, 1, 32767, -32768, 1);
        send_fields(0, 0, 2896, 2896, 4096, 0, 0);
        send_fields(0, 0, 7, 7, 4096, 0, 0);
        send_fields(1, 0, 0, 1, 1, 1, 1);
        send_fields(1, 1, 0, 0, 3, -3, 5);
        send_fields(1, 1, 1, 1, -1, 1, -1);
        send_fields(1, 2, 0, 0, 1, 1, 1);
        send_fields(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_fields(32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_fields(-32768, 32767, -32768, 32767, 32767, -32768, 32767);
        send_fields(-32768, 0, 0, 0, 32767, -32768, 32767);
        send_fields(0, -32768, 0, 32767, -32768, -32768, -32768);
        send_fields(1, 1, 1, 0, 32767, 32767, 32767);
        send_fields(-1, -1, -1, 0, -32768, -32768, -32768);
        send_fields(1, -1, 1, 3, 32767, -32768, 32767);
        send_fields(0, 1, 0, 0, 12345, -23456, 777);

        send_random(220);
        drain();
        send_idle_pct = 73;
        recv_stall_pct = 12;
        send_random(230);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(230);
        drain();

        $display("Sent %0d words through three idle and stall mixes; checked %0d results,",
                 words_sent, rot_sb.checked);
        $display("%0d with a zero quaternion and %0d clipped.",
                 rot_sb.zero_seen, rot_sb.sat_seen);
        if (rot_sb.errors == 0)
            $display("PASS quaternion_vector_rotate");
        else
            $display("FAIL quaternion_vector_rotate");
        $finish;
    end

endmodule
